FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the route table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Invariant checked on every edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

`endif

FILE: rtl/spr_pkg.sv
// ---------------------------------------------------------------------------
// spr_pkg
// Types and constants shared by the subnet peer route table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = 3 * ADDR_W;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HIT     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DEFAULT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic load;          // capture request fields
      logic add_entry;     // write route at entry count, bump count
      logic scan_clear;    // restart scan at entry 0
      logic scan_step;     // read next entry
      logic rsp_added;
      logic rsp_full;
      logic rsp_hit;
      logic rsp_fallback;  // default peer or miss
   } spr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic table_full;
      logic scan_end;
      logic hit;
   } spr_stat_type;

endpackage

`default_nettype wire

FILE: rtl/subnet_peer_route_table.sv
// ---------------------------------------------------------------------------
// subnet_peer_route_table
// First-match subnet route table with a configurable default peer.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add request
// appends a route (or reports the table full) in the add state, and its
// response is strobed on rsp_valid from the response register. A lookup
// reads the stored routes oldest first, one RAM read per cycle with the
// compare of each entry overlapped on the next read; it ends at the first
// hit or, once the scan index reaches the entry count, with the default
// peer or a miss. busy drops in the cycle the response is strobed, so the
// next request may be taken then. Each response is held for exactly one
// cycle; the receiver cannot stall it. The default peer register may be
// written whenever no request is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module subnet_peer_route_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_mode,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_route_subnet,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_route_mask,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_route_peer,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_dest_addr,
   output logic                              rsp_valid,
   output logic [spr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [spr_pkg::ADDR_W-1:0]        rsp_peer_addr,
   input  wire logic                         csr_wr_en,
   input  wire logic [spr_pkg::ADDR_W-1:0]   csr_wr_data
);

   import spr_pkg::*;

   spr_cmd_type  cmd;
   spr_stat_type stat;

   spr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .stat     (stat),
      .cmd      (cmd)
   );

   spr_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_route_subnet (req_route_subnet),
      .req_route_mask   (req_route_mask),
      .req_route_peer   (req_route_peer),
      .req_dest_addr    (req_dest_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_peer_addr    (rsp_peer_addr)
   );

endmodule

`default_nettype wire

FILE: rtl/spr_ram.sv
// ---------------------------------------------------------------------------
// spr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/spr_ctrl.sv
// ---------------------------------------------------------------------------
// spr_ctrl
// Request sequencer: add, or an in-order scan of the stored routes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_mode,
   output logic                       busy,
   input  wire spr_pkg::spr_stat_type stat,
   output spr_pkg::spr_cmd_type       cmd
);

   import spr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADD  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load       = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = req_mode ? S_SCAN : S_ADD;
            end
         end
         S_ADD: begin
            if (stat.table_full) begin
               cmd.rsp_full = 1'b1;
            end else begin
               cmd.add_entry = 1'b1;
               cmd.rsp_added = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // compare of the previous read overlaps the next read
            priority if (stat.hit) begin
               cmd.rsp_hit = 1'b1;
               state_in    = S_IDLE;
            end else if (stat.scan_end) begin
               cmd.rsp_fallback = 1'b1;
               state_in         = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_add_one_cycle, clock, reset, state_ff == S_ADD, state_ff == S_IDLE)
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `ASSERT_ALWAYS(a_one_rsp, clock, reset,
      $onehot0({cmd.rsp_added, cmd.rsp_full, cmd.rsp_hit, cmd.rsp_fallback}))

endmodule

`default_nettype wire

FILE: rtl/spr_dp.sv
// ---------------------------------------------------------------------------
// spr_dp
// Route storage, entry count, scan index, match compare and response register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spr_dp #(
   parameter int TABLE_DEPTH = 16,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_route_subnet,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_route_mask,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_route_peer,
   input  wire logic [spr_pkg::ADDR_W-1:0]   req_dest_addr,
   input  wire logic                         csr_wr_en,
   input  wire logic [spr_pkg::ADDR_W-1:0]   csr_wr_data,
   input  wire spr_pkg::spr_cmd_type         cmd,
   output spr_pkg::spr_stat_type             stat,
   output logic                              rsp_valid,
   output logic [spr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [spr_pkg::ADDR_W-1:0]        rsp_peer_addr
);

   import spr_pkg::*;

   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [ADDR_W-1:0]   subnet_ff, mask_ff, peer_ff, dest_ff;
   logic [ADDR_W-1:0]   default_peer_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_peer_ff, rsp_peer_in;
   logic [ENTRY_W-1:0]  rd_data;
   logic [ADDR_W-1:0]   ent_subnet, ent_mask, ent_peer;

   spr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.add_entry),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({subnet_ff, mask_ff, peer_ff}),
      .rd_en   (cmd.scan_step),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign ent_subnet = rd_data[3*ADDR_W-1:2*ADDR_W];
   assign ent_mask   = rd_data[2*ADDR_W-1:ADDR_W];
   assign ent_peer   = rd_data[ADDR_W-1:0];

   // stored subnet is compared unmasked
   assign stat.hit        = pend_ff && ((dest_ff & ent_mask) == ent_subnet);
   assign stat.scan_end   = (idx_ff == count_ff);
   assign stat.table_full = (count_ff >= DEPTH_C);

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      if (cmd.add_entry) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.scan_clear) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.scan_step) begin
         idx_in  = idx_ff + 1'b1;
         pend_in = 1'b1;
      end
   end

   always_comb begin
      priority if (cmd.rsp_added) begin
         rsp_status_in = ST_ADDED;
         rsp_peer_in   = '0;
      end else if (cmd.rsp_full) begin
         rsp_status_in = ST_FULL;
         rsp_peer_in   = '0;
      end else if (cmd.rsp_hit) begin
         rsp_status_in = ST_HIT;
         rsp_peer_in   = ent_peer;
      end else if (cmd.rsp_fallback) begin
         rsp_status_in = (default_peer_ff != '0) ? ST_DEFAULT : ST_MISS;
         rsp_peer_in   = default_peer_ff;
      end else begin
         rsp_status_in = rsp_status_ff;
         rsp_peer_in   = rsp_peer_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         idx_ff          <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         default_peer_ff <= '0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= cmd.rsp_added | cmd.rsp_full | cmd.rsp_hit | cmd.rsp_fallback;
         if (csr_wr_en) begin
            default_peer_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         subnet_ff <= req_route_subnet;
         mask_ff   <= req_route_mask;
         peer_ff   <= req_route_peer;
         dest_ff   <= req_dest_addr;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_peer_ff   <= rsp_peer_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_peer_addr = rsp_peer_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_C)
   `ASSERT_ALWAYS(a_idx_bound, clock, reset, idx_ff <= count_ff)
   `ASSERT_NEXT(a_add_count, clock, reset, cmd.add_entry,
      count_ff == CW'($past(count_ff) + 1'b1))

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for subnet_peer_route_table. Requests are driven on
// the falling edge and predicted on acceptance by an in-bench copy of the
// route list and default peer. Every strobed response is compared against
// the oldest outstanding prediction. Directed corner-case tests run before
// and after randomized phases with varying request gaps and default peers.
// ---------------------------------------------------------------------------
module tb_top;
   import spr_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam logic MODE_ADD     = 1'b0;
   localparam logic MODE_LOOKUP  = 1'b1;
   localparam int DRAIN_CYCLES   = 25;    // longer than the worst-case lookup
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] subnet;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] peer;
      logic [ADDR_W-1:0] dest;
   } route_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   peer;
   } route_rsp_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_mode;
   logic [ADDR_W-1:0]   req_route_subnet;
   logic [ADDR_W-1:0]   req_route_mask;
   logic [ADDR_W-1:0]   req_route_peer;
   logic [ADDR_W-1:0]   req_dest_addr;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_peer_addr;
   logic                csr_wr_en;
   logic [ADDR_W-1:0]   csr_wr_data;

   // bench copy of the route list
   logic [ADDR_W-1:0] rt_subnet [TABLE_DEPTH];
   logic [ADDR_W-1:0] rt_mask   [TABLE_DEPTH];
   logic [ADDR_W-1:0] rt_peer   [TABLE_DEPTH];
   int unsigned       rt_count;
   logic [ADDR_W-1:0] model_default;

   route_rsp_type awaited_rsp [$];
   int unsigned   mismatches;
   int unsigned   requests_sent;
   int unsigned   status_seen [5];
   int unsigned   idle_cycles;

   subnet_peer_route_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_route_subnet (req_route_subnet),
      .req_route_mask   (req_route_mask),
      .req_route_peer   (req_route_peer),
      .req_dest_addr    (req_dest_addr),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_peer_addr    (rsp_peer_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // first-match route selection; adds update the bench route list
   function automatic route_rsp_type predict_route(input route_req_type r);
      route_rsp_type res;
      res.status = ST_MISS;
      res.peer   = '0;
      if (r.mode == MODE_ADD) begin
         if (rt_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            rt_subnet[rt_count] = r.subnet;
            rt_mask[rt_count]   = r.mask;
            rt_peer[rt_count]   = r.peer;
            rt_count++;
            res.status = ST_ADDED;
         end
         return res;
      end
      for (int k = 0; k < rt_count; k++) begin
         if ((r.dest & rt_mask[k]) == rt_subnet[k]) begin
            res.status = ST_HIT;
            res.peer   = rt_peer[k];
            return res;
         end
      end
      if (model_default != '0) begin
         res.status = ST_DEFAULT;
         res.peer   = model_default;
      end
      return res;
   endfunction

   function automatic route_req_type make_add(input logic [ADDR_W-1:0] s,
                                              input logic [ADDR_W-1:0] m,
                                              input logic [ADDR_W-1:0] p);
      route_req_type r;
      r.mode   = MODE_ADD;
      r.subnet = s;
      r.mask   = m;
      r.peer   = p;
      r.dest   = $urandom;
      return r;
   endfunction

   function automatic route_req_type make_lookup(input logic [ADDR_W-1:0] d);
      route_req_type r;
      r.mode   = MODE_LOOKUP;
      r.subnet = $urandom;
      r.mask   = $urandom;
      r.peer   = $urandom;
      r.dest   = d;
      return r;
   endfunction

   // mostly prefix routes, often nested inside existing ones to exercise
   // first-match ordering; the rest have arbitrary masks
   function automatic route_req_type random_add();
      int unsigned       len;
      logic [ADDR_W-1:0] m;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] p;
      if ($urandom_range(9) < 7) begin
         len = $urandom_range(32, 1);
         m   = ~(32'hFFFF_FFFF >> len);
         if (rt_count > 0 && $urandom_range(1) == 1)
            s = rt_subnet[$urandom_range(rt_count - 1)] & m;
         else
            s = $urandom & m;
      end else begin
         m = $urandom;
         s = $urandom;
      end
      p = ($urandom_range(9) == 0) ? '0 : $urandom;
      return make_add(s, m, p);
   endfunction

   function automatic route_req_type random_lookup();
      int unsigned       k;
      logic [ADDR_W-1:0] d;
      if (rt_count > 0 && $urandom_range(3) != 0) begin
         k = $urandom_range(rt_count - 1);
         d = (rt_subnet[k] & rt_mask[k]) | ($urandom & ~rt_mask[k]);
      end else begin
         d = $urandom;
      end
      return make_lookup(d);
   endfunction

   task automatic send_request(input route_req_type r);
      @(negedge clock);
      start            <= 1'b1;
      req_mode         <= r.mode;
      req_route_subnet <= r.subnet;
      req_route_mask   <= r.mask;
      req_route_peer   <= r.peer;
      req_dest_addr    <= r.dest;
      do @(posedge clock); while (busy);
      awaited_rsp.push_back(predict_route(r));
      requests_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock) start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_default_peer(input logic [ADDR_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock) csr_wr_en <= 1'b0;
      model_default = v;
   endtask

   task automatic test_empty_table();
      write_default_peer('0);
      send_request(make_lookup('0));
      send_request(make_lookup('1));
      write_default_peer('1);
      send_request(make_lookup(32'h1234_5678));
   endtask

   task automatic test_route_adds();
      send_request(make_add(32'h0A00_0000, 32'hFF00_0000, 32'h1111_1111));
      // shadowed by the /8 above
      send_request(make_add(32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0022));
      // host route with a zero peer
      send_request(make_add(32'hC0A8_0101, 32'hFFFF_FFFF, '0));
      // subnet bits outside mask: never matches
      send_request(make_add(32'h0000_FF00, 32'h0000_F000, 32'h0000_0033));
      send_request(make_add('1, '1, '1));
      send_request(make_add(32'h0000_0001, '0, 32'h0000_0044));
      send_request(make_add('0, '1, 32'h0000_0055));
   endtask

   task automatic test_first_match_lookups();
      send_request(make_lookup(32'h0A01_2345));
      send_request(make_lookup(32'hC0A8_0101));
      send_request(make_lookup(32'h0000_FF00));
      send_request(make_lookup(32'h0000_F000));
      send_request(make_lookup('1));
      send_request(make_lookup('0));
      send_request(make_lookup(32'h1234_5678));
      write_default_peer('0);
      send_request(make_lookup(32'h1234_5678));
      send_request(make_lookup(32'h0000_0001));
   endtask

   task automatic run_random_phase(input int unsigned n_req, input int unsigned gap_pct,
                                   input logic [ADDR_W-1:0] dflt);
      write_default_peer(dflt);
      repeat (n_req) begin
         while ($urandom_range(99) < gap_pct) @(negedge clock) start <= 1'b0;
         send_request(($urandom_range(7) == 0) ? random_add() : random_lookup());
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(200, 0, '0);
      run_random_phase(200, 64, $urandom);
      run_random_phase(200, 17, '1);
      run_random_phase(200, 0, 32'h0000_0001);
   endtask

   task automatic test_table_full();
      while (rt_count < TABLE_DEPTH) send_request(random_add());
      send_request(random_add());
      send_request(make_add('1, '1, '1));
      send_request(random_lookup());
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      route_rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: unexpected response status=%0d peer=%h",
                        rsp_status, rsp_peer_addr);
         end else begin
            want = awaited_rsp.pop_front();
            if (want.status !== rsp_status || want.peer !== rsp_peer_addr) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: status exp %0d got %0d, peer exp %h got %h",
                           want.status, rsp_status, want.peer, rsp_peer_addr);
            end
            status_seen[want.status]++;
         end
      end
   end

   // watchdog: cycles with neither a request nor a response taken
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: watchdog timeout");
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = MODE_ADD;
      req_route_subnet = '0;
      req_route_mask   = '0;
      req_route_peer   = '0;
      req_dest_addr    = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      rt_count         = 0;
      model_default    = '0;
      mismatches       = 0;
      requests_sent    = 0;
      idle_cycles      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_empty_table();
      test_route_adds();
      test_first_match_lookups();
      test_random_traffic();
      test_table_full();
      wait_idle();

      $display("run: %0d requests, %0d routes stored, %0d adds refused on a full table",
               requests_sent, status_seen[ST_ADDED], status_seen[ST_FULL]);
      $display("lookups: %0d route hits, %0d via default peer, %0d misses",
               status_seen[ST_HIT], status_seen[ST_DEFAULT], status_seen[ST_MISS]);
      if (mismatches == 0 && awaited_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

FILE: subnet_peer_route_table.f
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_ram.sv
rtl/spr_ctrl.sv
rtl/spr_dp.sv
rtl/subnet_peer_route_table.sv
bench/tb_top.sv
